@@ rtl/core/cbb_pkg.sv @@
package cbb_pkg;

    localparam int COORD_W   = 32;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int RES_FRAC  = 30;
    localparam int RES_W     = 31;
    localparam int QMAG_W    = DIFF_W;          // |q| <= 4.0 = 2^32
    localparam int Q_W       = QMAG_W + 1;
    localparam int DIV_STEPS = 32;
    localparam int DIV_LAT   = DIV_STEPS + 3;
    localparam int NLANES    = 12;
    localparam int PROD_W    = QMAG_W + RES_W;
    localparam int TERM_W    = PROD_W - RES_FRAC + 1;
    localparam int SUM_W     = TERM_W + 1;

    localparam logic [RES_W-1:0]  ONE     = RES_W'(1) << RES_FRAC;
    localparam logic [QMAG_W-1:0] SAT_MAG = QMAG_W'(4) << RES_FRAC;

    typedef logic signed [DIFF_W-1:0] t_diff;
    typedef logic signed [Q_W-1:0]    t_q;
    typedef logic [RES_W-1:0]         t_basis;

    typedef struct packed {
        logic                neg;
        logic [PROD_W-1:0]   mag;
    } t_prod;

    function automatic logic [QMAG_W-1:0] qmag(input t_q q);
        logic [Q_W-1:0] a;
        a = q[Q_W-1] ? Q_W'(-q) : Q_W'(q);
        return a[QMAG_W-1:0];
    endfunction

    function automatic logic signed [TERM_W-1:0] term(input t_prod p);
        logic [TERM_W-1:0] m;
        m = {1'b0, p.mag[PROD_W-1:RES_FRAC]};
        return p.neg ? -$signed(m) : $signed(m);
    endfunction

    function automatic t_basis clamp(input logic signed [SUM_W-1:0] s);
        if (s < 0)
            return '0;
        if (s > $signed({{(SUM_W-RES_W){1'b0}}, ONE}))
            return ONE;
        return s[RES_W-1:0];
    endfunction

endpackage

@@ rtl/core/cbb_div.sv @@
module cbb_div (
    input  logic            i_clk,
    input  cbb_pkg::t_diff  i_num,
    input  cbb_pkg::t_diff  i_den,
    output cbb_pkg::t_q     o_q
);

    localparam int DW = cbb_pkg::DIFF_W;
    localparam int NS = cbb_pkg::DIV_STEPS;

    logic [DW-1:0] r_an, r_ad;
    logic          r_neg_b, r_zero_b;

    logic [DW-1:0] r_rem [0:NS];
    logic [NS-1:0] r_quo [0:NS];
    logic [DW-1:0] r_dv  [0:NS];
    logic [1:0]    r_lo  [0:NS];
    logic          r_sat [0:NS];
    logic          r_neg [0:NS];
    logic          r_zero[0:NS];

    always_ff @(posedge i_clk) begin
        r_an     <= i_num[DW-1] ? DW'(-i_num) : DW'(i_num);
        r_ad     <= i_den[DW-1] ? DW'(-i_den) : DW'(i_den);
        r_neg_b  <= i_num[DW-1] ^ i_den[DW-1];
        r_zero_b <= (i_den == '0);
    end

    // quotient below 4.0 means |num| >> 2 already sits below the divisor
    always_ff @(posedge i_clk) begin
        r_sat[0]  <= {2'b00, r_an} >= {r_ad, 2'b00};
        r_rem[0]  <= {2'b00, r_an[DW-1:2]};
        r_lo[0]   <= r_an[1:0];
        r_quo[0]  <= '0;
        r_dv[0]   <= r_ad;
        r_neg[0]  <= r_neg_b;
        r_zero[0] <= r_zero_b;
    end

    for (genvar k = 0; k < NS; k++) begin : g_step
        logic          w_bit;
        logic [DW:0]   w_t;
        logic          w_ge;
        if (k == 0) begin : g_b1
            assign w_bit = r_lo[k][1];
        end else if (k == 1) begin : g_b0
            assign w_bit = r_lo[k][0];
        end else begin : g_bz
            assign w_bit = 1'b0;
        end
        assign w_t  = {r_rem[k], w_bit};
        assign w_ge = w_t >= {1'b0, r_dv[k]};
        always_ff @(posedge i_clk) begin
            r_rem[k+1]  <= w_ge ? DW'(w_t - {1'b0, r_dv[k]}) : w_t[DW-1:0];
            r_quo[k+1]  <= {r_quo[k][NS-2:0], w_ge};
            r_dv[k+1]   <= r_dv[k];
            r_lo[k+1]   <= r_lo[k];
            r_sat[k+1]  <= r_sat[k];
            r_neg[k+1]  <= r_neg[k];
            r_zero[k+1] <= r_zero[k];
        end
    end

    logic [DW-1:0] w_mag;
    assign w_mag = r_sat[NS] ? cbb_pkg::SAT_MAG : {1'b0, r_quo[NS]};

    always_ff @(posedge i_clk) begin
        if (r_zero[NS])
            o_q <= '0;
        else if (r_neg[NS])
            o_q <= -$signed({1'b0, w_mag});
        else
            o_q <= $signed({1'b0, w_mag});
    end

endmodule

@@ rtl/core/cubic_bspline_basis_eval.sv @@
// cubic b-spline basis, cox-de boor recursion as a fixed pipeline
// throughput: one request per cycle; busy is never raised, the twelve knot
// ratios run in parallel restoring dividers, one quotient bit per stage
// reset: synchronous active-low i_rst_n clears all valid bits only
// the receiver cannot stall; o_valid marks a result for exactly one cycle
module cubic_bspline_basis_eval (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [cbb_pkg::COORD_W-1:0]  i_position,
    input  logic signed [cbb_pkg::COORD_W-1:0]  i_knot_a,
    input  logic signed [cbb_pkg::COORD_W-1:0]  i_knot_b,
    input  logic signed [cbb_pkg::COORD_W-1:0]  i_knot_c,
    input  logic signed [cbb_pkg::COORD_W-1:0]  i_knot_d,
    input  logic signed [cbb_pkg::COORD_W-1:0]  i_knot_e,
    output logic                                o_valid,
    output logic [cbb_pkg::RES_W-1:0]           o_basis_value
);

    localparam int NL = cbb_pkg::NLANES;
    localparam int DL = cbb_pkg::DIV_LAT;

    assign busy = 1'b0;

    cbb_pkg::t_diff w_t [0:4];
    cbb_pkg::t_diff w_u;
    cbb_pkg::t_diff n_num [0:NL-1];
    cbb_pkg::t_diff n_den [0:NL-1];
    logic [3:0]     n_n0;

    assign w_u    = cbb_pkg::DIFF_W'(i_position);
    assign w_t[0] = cbb_pkg::DIFF_W'(i_knot_a);
    assign w_t[1] = cbb_pkg::DIFF_W'(i_knot_b);
    assign w_t[2] = cbb_pkg::DIFF_W'(i_knot_c);
    assign w_t[3] = cbb_pkg::DIFF_W'(i_knot_d);
    assign w_t[4] = cbb_pkg::DIFF_W'(i_knot_e);

    // lanes: degree 1 j=0..2, degree 2 j=0..1, degree 3 j=0; left then right
    always_comb begin
        n_num[0]  = w_u - w_t[0];  n_den[0]  = w_t[1] - w_t[0];
        n_num[1]  = w_t[2] - w_u;  n_den[1]  = w_t[2] - w_t[1];
        n_num[2]  = w_u - w_t[1];  n_den[2]  = w_t[2] - w_t[1];
        n_num[3]  = w_t[3] - w_u;  n_den[3]  = w_t[3] - w_t[2];
        n_num[4]  = w_u - w_t[2];  n_den[4]  = w_t[3] - w_t[2];
        n_num[5]  = w_t[4] - w_u;  n_den[5]  = w_t[4] - w_t[3];
        n_num[6]  = w_u - w_t[0];  n_den[6]  = w_t[2] - w_t[0];
        n_num[7]  = w_t[3] - w_u;  n_den[7]  = w_t[3] - w_t[1];
        n_num[8]  = w_u - w_t[1];  n_den[8]  = w_t[3] - w_t[1];
        n_num[9]  = w_t[4] - w_u;  n_den[9]  = w_t[4] - w_t[2];
        n_num[10] = w_u - w_t[0];  n_den[10] = w_t[3] - w_t[0];
        n_num[11] = w_t[4] - w_u;  n_den[11] = w_t[4] - w_t[1];
        for (int j = 0; j < 4; j++)
            n_n0[j] = (w_u >= w_t[j]) && (w_u < w_t[j+1]);
    end

    cbb_pkg::t_diff r_num [0:NL-1];
    cbb_pkg::t_diff r_den [0:NL-1];
    cbb_pkg::t_q    w_q   [0:NL-1];
    logic           r_va;
    logic [3:0]     r_n0a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_va <= 1'b0;
        else
            r_va <= start;
        r_n0a <= n_n0;
        for (int l = 0; l < NL; l++) begin
            r_num[l] <= n_num[l];
            r_den[l] <= n_den[l];
        end
    end

    for (genvar l = 0; l < NL; l++) begin : g_lane
        cbb_div u_div (
            .i_clk (i_clk),
            .i_num (r_num[l]),
            .i_den (r_den[l]),
            .o_q   (w_q[l])
        );
    end

    logic [DL-1:0] r_dv;
    logic [3:0]    r_dn0 [0:DL-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_dv <= '0;
        else
            r_dv <= {r_dv[DL-2:0], r_va};
        r_dn0[0] <= r_n0a;
        for (int k = 1; k < DL; k++)
            r_dn0[k] <= r_dn0[k-1];
    end

    // degree 1: weights are 0 or 1.0, so a term is the ratio itself
    logic                r_v1;
    cbb_pkg::t_basis     r_n1 [0:2];
    cbb_pkg::t_q         r_q1 [6:11];
    logic signed [cbb_pkg::SUM_W-1:0] w_s1 [0:2];
    logic [3:0]          w_b0;

    assign w_b0 = r_dn0[DL-1];

    always_comb begin
        for (int j = 0; j < 3; j++)
            w_s1[j] = (w_b0[j]   ? cbb_pkg::SUM_W'(w_q[2*j])   : '0)
                    + (w_b0[j+1] ? cbb_pkg::SUM_W'(w_q[2*j+1]) : '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_v1 <= 1'b0;
        else
            r_v1 <= r_dv[DL-1];
        for (int j = 0; j < 3; j++)
            r_n1[j] <= cbb_pkg::clamp(w_s1[j]);
        for (int l = 6; l < 12; l++)
            r_q1[l] <= w_q[l];
    end

    // degree 2 products
    logic               r_v2;
    cbb_pkg::t_prod     r_p2 [0:3];
    cbb_pkg::t_q        r_q2 [10:11];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_v2 <= 1'b0;
        else
            r_v2 <= r_v1;
        r_p2[0] <= '{neg: r_q1[6][cbb_pkg::Q_W-1],
                     mag: cbb_pkg::qmag(r_q1[6]) * r_n1[0]};
        r_p2[1] <= '{neg: r_q1[7][cbb_pkg::Q_W-1],
                     mag: cbb_pkg::qmag(r_q1[7]) * r_n1[1]};
        r_p2[2] <= '{neg: r_q1[8][cbb_pkg::Q_W-1],
                     mag: cbb_pkg::qmag(r_q1[8]) * r_n1[1]};
        r_p2[3] <= '{neg: r_q1[9][cbb_pkg::Q_W-1],
                     mag: cbb_pkg::qmag(r_q1[9]) * r_n1[2]};
        r_q2[10] <= r_q1[10];
        r_q2[11] <= r_q1[11];
    end

    logic               r_v3;
    cbb_pkg::t_basis    r_n2 [0:1];
    cbb_pkg::t_q        r_q3 [10:11];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_v3 <= 1'b0;
        else
            r_v3 <= r_v2;
        for (int j = 0; j < 2; j++)
            r_n2[j] <= cbb_pkg::clamp(cbb_pkg::SUM_W'(cbb_pkg::term(r_p2[2*j]))
                                    + cbb_pkg::SUM_W'(cbb_pkg::term(r_p2[2*j+1])));
        r_q3[10] <= r_q2[10];
        r_q3[11] <= r_q2[11];
    end

    // degree 3
    logic               r_v4;
    cbb_pkg::t_prod     r_p4 [0:1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_v4 <= 1'b0;
        else
            r_v4 <= r_v3;
        r_p4[0] <= '{neg: r_q3[10][cbb_pkg::Q_W-1],
                     mag: cbb_pkg::qmag(r_q3[10]) * r_n2[0]};
        r_p4[1] <= '{neg: r_q3[11][cbb_pkg::Q_W-1],
                     mag: cbb_pkg::qmag(r_q3[11]) * r_n2[1]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            o_valid <= 1'b0;
        else
            o_valid <= r_v4;
        o_basis_value <= cbb_pkg::clamp(cbb_pkg::SUM_W'(cbb_pkg::term(r_p4[0]))
                                      + cbb_pkg::SUM_W'(cbb_pkg::term(r_p4[1])));
    end

endmodule
